[design/lsrs_pkg.sv]
// package: request and record types, header offsets and register map of the slot scanner
`default_nettype none

package lsrs_pkg;

	// header layout of one slot
	localparam logic [15:0] MIN_SLOT_BYTES = 16'd32;
	localparam logic [15:0] KLEN_LO_OFFSET = 16'd16;
	localparam logic [15:0] KLEN_HI_OFFSET = 16'd17;
	localparam logic [15:0] FLAG_OFFSET    = 16'd18;
	localparam logic [15:0] VLEN_OFFSET    = 16'd20;
	localparam logic [15:0] VLEN_END       = 16'd24;
	localparam logic [15:0] HASH_HI_OFFSET = 16'd8;
	localparam logic [15:0] HASH_END       = 16'd16;
	localparam logic [7:0]  FLAG_EMPTY     = 8'd0;
	localparam logic [7:0]  FLAG_LIVE      = 8'd1;
	localparam logic [7:0]  FLAG_TOMBSTONE = 8'd2;

	// register map
	localparam int          ADDR_W           = 3;
	localparam logic        REG_SLOT_BYTES   = 1'b0;
	localparam logic [15:0] SLOT_BYTES_RESET = 16'd32;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
	} req_t;

	typedef struct packed {
		logic [31:0] slot_index;
		logic [63:0] hash_low;
		logic [63:0] hash_high;
		logic [15:0] key_length;
		logic [31:0] value_length;
	} rec_t;

endpackage

`default_nettype wire

[design/lsrs_front.sv]
// front part: tracks slot position, captures header fields, queues live slots
`default_nettype none

module lsrs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [15:0]   slot_bytes,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lsrs_pkg::req_t req_data,
	input  wire logic          q_full,
	output logic               q_push,
	output lsrs_pkg::rec_t     q_data
);
	import lsrs_pkg::*;

	logic [15:0]      pos_q;
	logic [31:0]      cnt_q;
	logic [7:0][7:0]  hash_lo_q;
	logic [7:0][7:0]  hash_hi_q;
	logic [1:0][7:0]  klen_q;
	logic [7:0]       flag_q;
	logic [3:0][7:0]  vlen_q;

	logic [15:0]      pos_cur;
	logic [31:0]      cnt_cur;
	logic [7:0][7:0]  hash_lo_n;
	logic [7:0][7:0]  hash_hi_n;
	logic [1:0][7:0]  klen_n;
	logic [7:0]       flag_n;
	logic [3:0][7:0]  vlen_n;
	logic [15:0]      hash_hi_idx;
	logic [15:0]      vlen_idx;
	logic             slot_end;
	logic             emit;
	logic             accept;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	// position restart and header capture for the current byte
	always_comb begin
		pos_cur     = req_data.first_of_file ? 16'd0 : pos_q;
		cnt_cur     = req_data.first_of_file ? 32'd0 : cnt_q;
		hash_lo_n   = hash_lo_q;
		hash_hi_n   = hash_hi_q;
		klen_n      = klen_q;
		flag_n      = flag_q;
		vlen_n      = vlen_q;
		hash_hi_idx = pos_cur - HASH_HI_OFFSET;
		vlen_idx    = pos_cur - VLEN_OFFSET;
		if (pos_cur < HASH_HI_OFFSET) begin
			hash_lo_n[pos_cur[2:0]] = req_data.data_byte;
		end else if (pos_cur < HASH_END) begin
			hash_hi_n[hash_hi_idx[2:0]] = req_data.data_byte;
		end else if (pos_cur == KLEN_LO_OFFSET) begin
			klen_n[0] = req_data.data_byte;
		end else if (pos_cur == KLEN_HI_OFFSET) begin
			klen_n[1] = req_data.data_byte;
		end else if (pos_cur == FLAG_OFFSET) begin
			flag_n = req_data.data_byte;
		end else if (pos_cur >= VLEN_OFFSET && pos_cur < VLEN_END) begin
			vlen_n[vlen_idx[1:0]] = req_data.data_byte;
		end
	end

	// end of slot and live check
	always_comb begin
		slot_end = ({1'b0, pos_cur} + 17'd1) >= {1'b0, slot_bytes};
		emit     = slot_end && (slot_bytes >= MIN_SLOT_BYTES) && (flag_n == FLAG_LIVE);
	end

	// record toward the back part
	always_comb begin
		q_push              = accept && emit;
		q_data.slot_index   = cnt_cur;
		q_data.hash_low     = hash_lo_n;
		q_data.hash_high    = hash_hi_n;
		q_data.key_length   = klen_n;
		q_data.value_length = vlen_n;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			cnt_q     <= '0;
			hash_lo_q <= '0;
			hash_hi_q <= '0;
			klen_q    <= '0;
			flag_q    <= '0;
			vlen_q    <= '0;
		end else if (accept) begin
			hash_lo_q <= hash_lo_n;
			hash_hi_q <= hash_hi_n;
			klen_q    <= klen_n;
			vlen_q    <= vlen_n;
			if (slot_end) begin
				pos_q  <= '0;
				cnt_q  <= cnt_cur + 32'd1;
				flag_q <= '0;
			end else begin
				pos_q  <= pos_cur + 16'd1;
				cnt_q  <= cnt_cur;
				flag_q <= flag_n;
			end
		end
	end

endmodule

`default_nettype wire

[design/lsrs_queue.sv]
// short record queue between the front and back parts
`default_nettype none

module lsrs_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lsrs_pkg::rec_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output lsrs_pkg::rec_t     pop_data
);
	import lsrs_pkg::*;

	rec_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/lsrs_back.sv]
// back part: output register that hands records to the receiver
`default_nettype none

module lsrs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_not_empty,
	input  wire lsrs_pkg::rec_t q_data,
	output logic               q_pop,
	output logic               rec_valid,
	input  wire logic          rec_stall,
	output lsrs_pkg::rec_t     rec_data
);
	import lsrs_pkg::*;

	logic valid_q;
	rec_t data_q;

	assign rec_valid = valid_q;
	assign rec_data  = data_q;

	// load when the register is empty or its record is taken
	assign q_pop = q_not_empty && (!valid_q || !rec_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !rec_stall) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_data;
		end
	end

endmodule

`default_nettype wire

[design/live_slot_record_scanner.sv]
// top level of the live slot record scanner: register port, front, queue and back
//
// Takes a file one byte per request on the req channel (req_valid, req_stall,
// req_data) and views it as fixed-size slots whose length in bytes is set
// through the APB-style register port (register 0 at byte address 0, reset 32).
// Bytes 0..15 of a slot are the hash, 16..17 the key length, 18 the flag and
// 20..23 the value length. On the last byte of a slot whose flag is 1, one
// record goes out on the rec channel (rec_valid, rec_stall, rec_data) with
// the slot number, hash halves and lengths. first_of_file restarts the slot
// position and slot number. Partial slots and other flags give no record.
// One byte is taken every cycle while req_stall is low. The record of a live
// slot is queued and then held in the output register, which drives rec_valid.
// A stalled receiver first fills the output register and the two-entry
// record queue; only once the queue is full is req_stall raised, and it then
// holds every byte, not only slot ends. Reset empties the queue and output
// register and clears all scan state; the slot length returns to 32.
`default_nettype none

module live_slot_record_scanner (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [lsrs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire lsrs_pkg::req_t       req_data,
	output logic                      rec_valid,
	input  wire logic                 rec_stall,
	output lsrs_pkg::rec_t            rec_data
);
	import lsrs_pkg::*;

	logic [15:0] slot_bytes_q;
	logic        q_full;
	logic        q_push;
	rec_t        q_push_data;
	logic        q_pop;
	logic        q_not_empty;
	rec_t        q_pop_data;
	logic        reg_sel;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1] == REG_SLOT_BYTES;
	assign prdata  = reg_sel ? {16'd0, slot_bytes_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= SLOT_BYTES_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			slot_bytes_q <= pwdata[15:0];
		end
	end

	lsrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_bytes (slot_bytes_q),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_push_data)
	);

	lsrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_pop_data)
	);

	lsrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_pop_data),
		.q_pop       (q_pop),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.rec_data    (rec_data)
	);

endmodule

`default_nettype wire
